// ===== design/yaz0_pkg.sv =====
package yaz0_pkg;
  localparam int unsigned WinDepth = 4096;
  localparam int unsigned WinAw = $clog2(WinDepth);
  localparam int unsigned ChunkBytes = 8;
  localparam int unsigned ChunkFw = $clog2(ChunkBytes + 1);
  localparam int unsigned HeaderBytes = 16;
  localparam logic [7:0] CodeLitMask = 8'h80;
  localparam logic [8:0] LongLenBase = 9'h012;
  localparam logic [7:0] AddrSkip = 8'h00;
  localparam logic [7:0] AddrMax = 8'h04;

  typedef enum logic [7:0] {
    PhHeader = 8'b0000_0001,
    PhCode   = 8'b0000_0010,
    PhLit    = 8'b0000_0100,
    PhRef1   = 8'b0000_1000,
    PhRef2   = 8'b0001_0000,
    PhRef3   = 8'b0010_0000,
    PhCopy   = 8'b0100_0000,
    PhDone   = 8'b1000_0000
  } phase_e;

  typedef struct packed {
    logic        we;
    logic [WinAw-1:0] waddr;
    logic [7:0]  wdata;
    logic [WinAw-1:0] raddr;
  } win_req_t;
endpackage

// ===== design/yaz0_ram.sv =====
module yaz0_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 4096
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];
  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[waddr_i] <= wdata_i;
    rdata_o <= mem_q[raddr_i];
  end
endmodule

// ===== design/yaz0_window_decoder_top.sv =====
// Yaz0 decoder: feed the stream (header included) one byte per transaction on s_axis;
// packed results (up to 8 bytes) come out on m_axis. After its last byte, a
// back-reference holds off the input while it copies byte by byte (read, then write),
// since the 4096-byte history RAM has a single read port. Every accepted or copied
// byte waits for a free output register, so a stalled m_axis stalls decoding. After the
// last result, input is drained and ignored until reset. Write skip_count at 0x0 and
// max_output at 0x4 only while idle.
module yaz0_window_decoder_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // stream_byte
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [103:0] m_axis_tdata,  // out_bytes, byte_count, status, total_emitted
  output logic        m_axis_tlast    // last_chunk
);
  logic [31:0] skip_q, max_q;
  yaz0_pkg::phase_e ph_q;
  logic [4:0]  hidx_q;
  logic        bad_q;
  logic [31:0] dlen_q, prod_q, emit_q;
  logic [7:0]  code_q, r1_q;
  logic [3:0]  left_q;
  logic [yaz0_pkg::WinAw-1:0] wpos_q, src_q, ref_dist;
  logic [8:0]  len_q;
  logic [63:0] cdat_q;
  logic [yaz0_pkg::ChunkFw-1:0] cfill_q;
  logic        ov_q, olast_q, ost_q;
  logic [63:0] odat_q;
  logic [3:0]  ocnt_q;
  logic [31:0] otot_q;
  logic        rd_v_q;
  logic [7:0]  rdata;
  yaz0_pkg::win_req_t req;
  logic [31:0] lim;
  logic        out_free, acc, put, show, fin, full;
  logic        bad_nx, hdr_out, oload;
  logic [7:0]  pb;

  assign pready = 1'b1;
  assign prdata = (paddr[2]) ? max_q : skip_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      skip_q <= '0;
      max_q <= '1;
    end else if (psel && penable && pwrite) begin
      if ({5'd0, paddr} == yaz0_pkg::AddrSkip) skip_q <= pwdata;
      if ({5'd0, paddr} == yaz0_pkg::AddrMax) max_q <= pwdata;
    end
  end

  assign lim = ((dlen_q > skip_q) ? dlen_q - skip_q : 32'd0) < max_q ?
               ((dlen_q > skip_q) ? dlen_q - skip_q : 32'd0) : max_q;
  assign out_free = !ov_q || m_axis_tready;
  assign s_axis_tready = out_free && ph_q != yaz0_pkg::PhCopy;
  assign acc = s_axis_tvalid && s_axis_tready;
  assign ref_dist = {r1_q[3:0], s_axis_tdata};

  // byte into window
  always_comb begin
    put = 1'b0;
    pb = s_axis_tdata;
    if (ph_q == yaz0_pkg::PhLit && acc) put = 1'b1;
    if (ph_q == yaz0_pkg::PhCopy && rd_v_q && out_free) begin
      put = 1'b1;
      pb = rdata;
    end
  end
  assign show = prod_q >= skip_q;
  assign full = ({1'b0, cfill_q} + 1'b1) >= yaz0_pkg::ChunkFw'(yaz0_pkg::ChunkBytes);
  assign fin = put && show && (emit_q + 1 >= lim);

  always_comb begin
    bad_nx = bad_q;
    if (hidx_q == 5'd0 && s_axis_tdata != "Y") bad_nx = 1'b1;
    if (hidx_q == 5'd1 && s_axis_tdata != "a") bad_nx = 1'b1;
    if (hidx_q == 5'd2 && s_axis_tdata != "z") bad_nx = 1'b1;
    if (hidx_q == 5'd3 && s_axis_tdata != "0") bad_nx = 1'b1;
  end
  assign hdr_out = ph_q == yaz0_pkg::PhHeader && acc &&
                   ((hidx_q == 5'd3 && bad_nx) ||
                    (hidx_q == 5'(yaz0_pkg::HeaderBytes - 1) && lim == 32'd0));
  assign oload = (put && show && (fin || full)) || hdr_out;

  always_comb begin
    req.we = put;
    req.waddr = wpos_q;
    req.wdata = pb;
    req.raddr = src_q;
  end

  yaz0_ram #(.Width(8), .Depth(yaz0_pkg::WinDepth)) u_win (
    .clk_i, .we_i(req.we), .waddr_i(req.waddr), .wdata_i(req.wdata),
    .raddr_i(req.raddr), .rdata_o(rdata)
  );

  logic [7:0] code_nx;
  assign code_nx = {code_q[6:0], 1'b0};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ph_q <= yaz0_pkg::PhHeader; hidx_q <= '0; bad_q <= 1'b0; dlen_q <= '0;
      prod_q <= '0; emit_q <= '0; code_q <= '0; left_q <= '0; r1_q <= '0;
      wpos_q <= '0; src_q <= '0; len_q <= '0; cdat_q <= '0; cfill_q <= '0;
      ov_q <= 1'b0; olast_q <= 1'b0; ost_q <= 1'b0; odat_q <= '0; ocnt_q <= '0;
      otot_q <= '0; rd_v_q <= 1'b0;
    end else begin
      if (oload) ov_q <= 1'b1;
      else if (m_axis_tready) ov_q <= 1'b0;
      // read issued, then held until the byte is written
      rd_v_q <= (ph_q == yaz0_pkg::PhCopy) && !put;
      if (put) begin
        wpos_q <= wpos_q + 1'b1;
        if (prod_q != '1) prod_q <= prod_q + 1;
        if (show) begin
          emit_q <= emit_q + 1;
          if (fin || full) begin
            olast_q <= fin; ost_q <= 1'b0;
            odat_q <= cdat_q | (64'(pb) << (8 * cfill_q));
            ocnt_q <= 4'(cfill_q) + 4'd1; otot_q <= emit_q + 1;
            cdat_q <= '0; cfill_q <= '0;
          end else begin
            cdat_q <= cdat_q | (64'(pb) << (8 * cfill_q));
            cfill_q <= cfill_q + 1'b1;
          end
        end
      end
      if (fin) ph_q <= yaz0_pkg::PhDone;
      else begin
        unique case (ph_q)
          yaz0_pkg::PhHeader: if (acc) begin
            hidx_q <= hidx_q + 1'b1;
            bad_q <= bad_nx;
            if (hidx_q >= 5'd4 && hidx_q < 5'd8) dlen_q <= {dlen_q[23:0], s_axis_tdata};
            if (hidx_q == 5'd3 && bad_nx) begin
              olast_q <= 1'b1; ost_q <= 1'b1; odat_q <= '0;
              ocnt_q <= '0; otot_q <= '0; ph_q <= yaz0_pkg::PhDone;
            end else if (hidx_q == 5'(yaz0_pkg::HeaderBytes - 1)) begin
              if (lim == 0) begin
                olast_q <= 1'b1; ost_q <= 1'b0; odat_q <= '0;
                ocnt_q <= '0; otot_q <= '0; ph_q <= yaz0_pkg::PhDone;
              end else ph_q <= yaz0_pkg::PhCode;
            end
          end
          yaz0_pkg::PhCode: if (acc) begin
            code_q <= s_axis_tdata; left_q <= 4'd8;
            ph_q <= (s_axis_tdata & yaz0_pkg::CodeLitMask) != 0 ?
                    yaz0_pkg::PhLit : yaz0_pkg::PhRef1;
          end
          yaz0_pkg::PhLit: if (acc) begin
            code_q <= code_nx; left_q <= left_q - 1'b1;
            ph_q <= (left_q == 4'd1) ? yaz0_pkg::PhCode :
                    (code_nx & yaz0_pkg::CodeLitMask) != 0 ? yaz0_pkg::PhLit :
                    yaz0_pkg::PhRef1;
          end
          yaz0_pkg::PhRef1: if (acc) begin
            r1_q <= s_axis_tdata; ph_q <= yaz0_pkg::PhRef2;
          end
          yaz0_pkg::PhRef2: if (acc) begin
            src_q <= wpos_q - ref_dist - 1'b1;
            if (r1_q[7:4] == 4'd0) ph_q <= yaz0_pkg::PhRef3;
            else begin
              len_q <= 9'(r1_q[7:4]) + 9'd2; ph_q <= yaz0_pkg::PhCopy;
            end
          end
          yaz0_pkg::PhRef3: if (acc) begin
            len_q <= 9'(s_axis_tdata) + yaz0_pkg::LongLenBase; ph_q <= yaz0_pkg::PhCopy;
          end
          yaz0_pkg::PhCopy: begin
            if (put) begin
              len_q <= len_q - 1'b1;
              src_q <= src_q + 1'b1;
              if (len_q == 9'd1) begin
                code_q <= code_nx; left_q <= left_q - 1'b1;
                ph_q <= (left_q == 4'd1) ? yaz0_pkg::PhCode :
                        (code_nx & yaz0_pkg::CodeLitMask) != 0 ? yaz0_pkg::PhLit :
                        yaz0_pkg::PhRef1;
              end
            end
          end
          yaz0_pkg::PhDone: ;
          default: ;
        endcase
      end
    end
  end

  assign m_axis_tvalid = ov_q;
  assign m_axis_tlast = olast_q;
  assign m_axis_tdata = {3'b000, otot_q, ost_q, ocnt_q, odat_q};
endmodule

// ===== design/yaz0_checker.sv =====
module yaz0_checker (
  input logic clk_i, rst_ni, m_axis_tvalid, m_axis_tready, m_axis_tlast,
  input logic [103:0] m_axis_tdata
);
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("output changed while stalled");
  a_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[67:64] <= 4'd8)
    else $error("byte count too large");
  a_bad: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[68] |-> m_axis_tlast && m_axis_tdata[67:64] == 4'd0)
    else $error("bad magic result malformed");
endmodule

bind yaz0_window_decoder_top yaz0_checker u_chk (.*);
